// ===== sv/hanms_pkg.sv =====
// ---------------------------------------------------------------------------
// hanms_pkg
// Shared constants for the Hough accumulator 3x3 non-maximum suppression unit.
// ---------------------------------------------------------------------------
package hanms_pkg;

    // geometry limits
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_ROWS  = 1024;

    // field widths
    localparam int VAL_W  = 31;                   // vote count
    localparam int POS_W  = 10;                   // row / column position
    localparam int DIM_W  = 11;                   // geometry registers
    localparam int ADDR_W = $clog2(MAX_WIDTH);    // line buffer address
    localparam int LINE_W = 2 * VAL_W;            // {two rows above, row above}

    // stream data widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VOTE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS    = 2'd2;

    // geometry bounds
    localparam logic [DIM_W-1:0] DIM_MIN   = 11'd3;
    localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] ROWS_MAX  = DIM_W'(MAX_ROWS);

    // clamp a geometry register into [DIM_MIN, hi]
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        begin
            if (v < DIM_MIN)
            begin
                r = DIM_MIN;
            end
            else if (v > hi)
            begin
                r = hi;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// ===== sv/hough_accumulator_nms_3x3_unit.sv =====
// ---------------------------------------------------------------------------
// hough_accumulator_nms_3x3_unit
// 3x3 non-maximum suppression over a raster stream of Hough accumulator
// cells. Two line buffers in one RAM feed a 3x3 window; each interior cell
// yields a suppression flag with its row and column.
// ---------------------------------------------------------------------------
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+---------------------------------
//  s_axis    | in  | s_axis_tvalid / tready  | tdata: acc_value; tuser: first
//  m_axis    | out | m_axis_tvalid / tready  | tdata: row, col, suppressed; tlast
//  cfg       | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One cell is accepted per cycle while stage 1 can advance; the line buffer
//  RAM port (one read, one write per cycle) sets that rate.
//  A result is loaded into the output register when its cell advances out
//  of stage 1. Border cells give no result.
//  Reset clears the position counters, window and pipeline valids; the line
//  buffers need no clearing pass.
//  A stalled output holds its result; a cell waiting behind it in stage 1
//  holds too and drops s_axis_tready until the output register frees up.
//  Configuration writes are always taken.
// ---------------------------------------------------------------------------
module hough_accumulator_nms_3x3_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // input cell stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hanms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [30:0] acc_value, [31] zero
    input  logic                              s_axis_tuser,  // [0] first_of_frame
    // decision stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hanms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [9:0] cell_row,
                                                             // [19:10] cell_col,
                                                             // [20] suppressed, [23:21] zero
    output logic                              m_axis_tlast,  // last_of_frame
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hanms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hanms_pkg::VAL_W-1:0]       cfg_data
);

    localparam int VW = hanms_pkg::VAL_W;
    localparam int PW = hanms_pkg::POS_W;
    localparam int DW = hanms_pkg::DIM_W;
    localparam int AW = hanms_pkg::ADDR_W;
    localparam int LW = hanms_pkg::LINE_W;

    // configuration registers
    logic [VW-1:0] vote_threshold_reg;
    logic [DW-1:0] active_width_reg;
    logic [DW-1:0] active_rows_reg;

    // position counters
    logic [PW-1:0] row_count_reg, row_count_next;
    logic [PW-1:0] col_count_reg, col_count_next;

    // stage 1: cell waiting for its line buffer column
    logic          s1_valid_reg;
    logic [VW-1:0] s1_value_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic [PW-1:0] s1_row_reg;
    logic [PW-1:0] s1_col_reg;

    // read-during-write bypass
    logic          byp_sel_reg;
    logic [LW-1:0] byp_data_reg;

    // 3x3 window, [row 0 top..2 bottom][col 0 left..2 right]
    logic [VW-1:0] win_reg  [3][3];
    logic [VW-1:0] win_next [3][3];

    // output register
    logic          out_valid_reg;
    logic [PW-1:0] out_row_reg;
    logic [PW-1:0] out_col_reg;
    logic          out_supp_reg;
    logic          out_last_reg;

    // stage 0 signals
    logic          in_acc;
    logic          s1_adv;
    logic          out_free;
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [PW-1:0] cur_row;
    logic [PW-1:0] cur_col;
    logic [DW-1:0] cur_row_x;
    logic [DW-1:0] cur_col_x;
    logic          cur_emit;
    logic          cur_last;

    // stage 1 signals
    logic [LW-1:0] ram_rd_data;
    logic [LW-1:0] line_word;
    logic [LW-1:0] wr_word;
    logic          greater;
    logic          supp;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_threshold_reg <= '0;
            active_width_reg   <= hanms_pkg::WIDTH_MAX;
            active_rows_reg    <= hanms_pkg::ROWS_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hanms_pkg::REG_VOTE_THRESHOLD: vote_threshold_reg <= cfg_data;
                hanms_pkg::REG_ACTIVE_WIDTH:   active_width_reg   <= cfg_data[DW-1:0];
                hanms_pkg::REG_ACTIVE_ROWS:    active_rows_reg    <= cfg_data[DW-1:0];
                default:                       ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // position of the incoming cell and counter advance
    // ---------------------------------------------------------------
    assign w_eff     = hanms_pkg::clamp_dim(active_width_reg, hanms_pkg::WIDTH_MAX);
    assign h_eff     = hanms_pkg::clamp_dim(active_rows_reg, hanms_pkg::ROWS_MAX);
    assign cur_row   = s_axis_tuser ? '0 : row_count_reg;
    assign cur_col   = s_axis_tuser ? '0 : col_count_reg;
    assign cur_row_x = {1'b0, cur_row};
    assign cur_col_x = {1'b0, cur_col};
    assign cur_emit  = (cur_row >= PW'(2)) && (cur_col >= PW'(2))
                       && (cur_row_x < h_eff) && (cur_col_x < w_eff);
    assign cur_last  = (cur_row_x == h_eff - DW'(1)) && (cur_col_x == w_eff - DW'(1));

    always_comb
    begin
        if (cur_col_x >= w_eff - DW'(1))
        begin
            col_count_next = '0;
            row_count_next = (cur_row_x >= h_eff - DW'(1)) ? '0 : cur_row + PW'(1);
        end
        else
        begin
            col_count_next = cur_col + PW'(1);
            row_count_next = (cur_row_x >= h_eff) ? '0 : cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else if (in_acc)
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // ---------------------------------------------------------------
    // line buffer RAM: {two rows above, row above} per column
    // ---------------------------------------------------------------
    hanms_ram #(
        .WIDTH (LW),
        .DEPTH (hanms_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_word),
        .rd_en   (in_acc),
        .rd_addr (cur_col[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // take the write of the same edge when the read hits its column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_sel_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            byp_sel_reg <= s1_adv && (s1_addr_reg == cur_col[AW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            byp_data_reg <= wr_word;
        end
    end

    assign line_word = byp_sel_reg ? byp_data_reg : ram_rd_data;
    assign wr_word   = {line_word[VW-1:0], s1_value_reg};

    // ---------------------------------------------------------------
    // stage 1 register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_value_reg <= s_axis_tdata[VW-1:0];
            s1_addr_reg  <= cur_col[AW-1:0];
            s1_emit_reg  <= cur_emit;
            s1_last_reg  <= cur_last;
            s1_row_reg   <= cur_row - PW'(1);
            s1_col_reg   <= cur_col - PW'(1);
        end
    end

    // ---------------------------------------------------------------
    // window shift and neighbor compare
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = line_word[LW-1:VW];
        win_next[1][2] = line_word[VW-1:0];
        win_next[2][2] = s1_value_reg;
    end

    always_comb
    begin
        greater = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1) && (win_next[i][j] > win_next[1][1]))
                begin
                    greater = 1'b1;
                end
            end
        end
    end

    assign supp = (win_next[1][1] > vote_threshold_reg) && greater;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_adv && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            out_row_reg  <= s1_row_reg;
            out_col_reg  <= s1_col_reg;
            out_supp_reg <= supp;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_supp_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    // a bypass armed by an accepted request needs a write-back on that edge
    a_byp_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_acc) && byp_sel_reg |-> $past(s1_adv))
        else $error("line buffer bypass without a write-back");

    // an interior decision reaches the output register on the next edge
    a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_emit_reg |=> m_axis_tvalid)
        else $error("decision lost between stage 1 and output");

    // decided cells are never in the top row or left column
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_row_reg != '0) && (out_col_reg != '0))
        else $error("border cell decided");
`endif

endmodule

// ===== sv/hanms_ram.sv =====
// ---------------------------------------------------------------------------
// hanms_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. A read of the address written at the same edge
// returns the old contents.
// ---------------------------------------------------------------------------
module hanms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
